// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the block's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define TRTE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define TRTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/trte_pkg.sv =====
// ----------------------------------------------------------------------------
// trte_pkg
// Types, codes and constants shared by the tick RSI trend engine.
// ----------------------------------------------------------------------------
`default_nettype none

package trte_pkg;

  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_PRICE_BITS = 24;
  localparam int MIN_WINDOW     = 2;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;

  localparam int WLEN_W   = 7;
  localparam int ALPHA_W  = 16;
  localparam int SPREAD_W = 24;
  localparam int THR_W    = 23;
  localparam int RSI_W    = 15;
  localparam int TREND_W  = 24;
  localparam int DIR_W    = 2;
  localparam int QUOT_W   = 15;

  localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;
  localparam logic [RSI_W-1:0] RSI_MID  = 15'd12800;
  localparam int               ROUND_HALF = 32768;

  localparam logic [WLEN_W-1:0]   WLEN_RESET   = 7'd14;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd32768;
  localparam logic [SPREAD_W-1:0] SPREAD_RESET = 24'd50;
  localparam logic [THR_W-1:0]    THR_RESET    = 23'd6554;

  localparam int OUT_DATA_W    = 48;
  localparam int OUT_USER_W    = 3;
  localparam int OUT_RSI_LSB   = 0;
  localparam int OUT_TREND_LSB = 15;
  localparam int OUT_DIR_LSB   = 39;
  localparam int USR_ACCEPTED    = 0;
  localparam int USR_RSI_READY   = 1;
  localparam int USR_TREND_VALID = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW = 8'd0,
    CFG_ALPHA  = 8'd1,
    CFG_SPREAD = 8'd2,
    CFG_THRESH = 8'd3
  } cfg_index_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 2'd0,
    DIR_LONG  = 2'd1,
    DIR_SHORT = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    TICK_DROP,
    TICK_FIRST,
    TICK_CHANGE
  } tick_kind_e;

  typedef struct packed {
    tick_kind_e kind;
    logic       up;
  } tick_ctl_t;

  typedef struct packed {
    logic [WLEN_W-1:0]   window_length;
    logic [ALPHA_W-1:0]  alpha;
    logic [SPREAD_W-1:0] spread_limit;
    logic [THR_W-1:0]    threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_EMA1,
    ST_EMA2,
    ST_DONE
  } back_state_e;

endpackage

`default_nettype wire

// ===== hdl/trte_front.sv =====
// ----------------------------------------------------------------------------
// trte_front
// Spread filter and doubled-mid tracking; classifies each tick for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module trte_front #(
  parameter int PRICE_BITS = trte_pkg::DEF_PRICE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [PRICE_BITS-1:0]         ask_i,
  input  logic [PRICE_BITS-1:0]         bid_i,
  input  logic [trte_pkg::SPREAD_W-1:0] spread_limit_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output trte_pkg::tick_ctl_t           q_ctl_o,
  output logic [PRICE_BITS:0]           q_mag_o
);
  import trte_pkg::*;

  localparam int CMP_W = 33;

  logic [PRICE_BITS-1:0] spread;
  logic [PRICE_BITS:0]   mid2;
  logic [PRICE_BITS:0]   last_mid_q;
  logic                  last_valid_q;
  logic                  pass;
  logic                  take;

  assign spread     = ask_i - bid_i;
  assign pass       = (ask_i > bid_i) && (CMP_W'(spread) <= CMP_W'(spread_limit_i));
  assign mid2       = {1'b0, ask_i} + {1'b0, bid_i};
  assign take       = in_valid_i && q_ready_i;
  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;

  always_comb begin
    q_ctl_o.up = mid2 > last_mid_q;
    q_mag_o    = q_ctl_o.up ? (mid2 - last_mid_q) : (last_mid_q - mid2);
    if (!pass) begin
      q_ctl_o.kind = TICK_DROP;
    end else if (!last_valid_q) begin
      q_ctl_o.kind = TICK_FIRST;
    end else begin
      q_ctl_o.kind = TICK_CHANGE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= 1'b0;
    end else if (take && pass) begin
      last_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pass) begin
      last_mid_q <= mid2;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/trte_queue.sv =====
// ----------------------------------------------------------------------------
// trte_queue
// Two-entry queue between the tick classifier and the RSI back end.
// ----------------------------------------------------------------------------
`default_nettype none

module trte_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int               DEPTH = 2;
  localparam logic [1:0]       FULL  = 2'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = count_q != FULL;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/trte_back.sv =====
// ----------------------------------------------------------------------------
// trte_back
// Sliding gain/loss window, iterative RSI divide, slope EMA and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trte_back #(
  parameter int MAX_WINDOW = trte_pkg::DEF_MAX_WINDOW,
  parameter int PRICE_BITS = trte_pkg::DEF_PRICE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  trte_pkg::cfg_t                  cfg_i,
  input  logic                            restart_i,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  trte_pkg::tick_ctl_t             item_ctl_i,
  input  logic [PRICE_BITS:0]             item_mag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [trte_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic [trte_pkg::OUT_USER_W-1:0] out_user_o
);
  import trte_pkg::*;

  localparam int EW     = PRICE_BITS + 1;
  localparam int IW     = $clog2(MAX_WINDOW);
  localparam int LW     = $clog2(MAX_WINDOW + 1);
  localparam int OW     = LW + 1;
  localparam int SW     = EW + $clog2(MAX_WINDOW);
  localparam int NW     = SW + QUOT_W;
  localparam int CNT_W  = $clog2(QUOT_W);
  localparam int DIFF_W = TREND_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;

  function automatic logic [LW-1:0] clamp_len(logic [WLEN_W-1:0] w);
    int v;
    v = int'(w);
    if (v < MIN_WINDOW) v = MIN_WINDOW;
    if (v > MAX_WINDOW) v = MAX_WINDOW;
    return LW'(v);
  endfunction

  back_state_e state_q, state_d;

  logic [2*EW-1:0] ring_mem [MAX_WINDOW];
  logic [2*EW-1:0] rd_q;

  logic [LW-1:0]   len;
  logic [LW-1:0]   fill_q;
  logic [LW-1:0]   fill_next;
  logic [IW-1:0]   ptr_q;
  logic [IW-1:0]   ptr_next;
  logic [IW-1:0]   old_idx;
  logic [OW-1:0]   old_sum;
  logic            evict;
  logic            full_next;

  logic [SW-1:0]   gain_q, loss_q, dsum_q;
  logic [NW-1:0]   prod_q;
  logic [NW-1:0]   num;
  logic [SW-1:0]   rem_q, rem_next;
  logic [SW:0]     trial;
  logic            ge;
  logic [QUOT_W-1:0] low_q, quot_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [RSI_W-1:0]          rsi_q;
  logic signed [TREND_W-1:0] trend_q;
  logic                      seeded_q;
  logic signed [RSI_W:0]     rsi_diff;
  logic signed [TREND_W-1:0] slope;
  logic signed [DIFF_W-1:0]  ema_diff;
  logic signed [PROD_W-1:0]  ema_q;
  logic signed [PROD_W-1:0]  ema_round;
  logic signed [ALPHA_W:0]   alpha_s;

  tick_kind_e      kind_q;
  logic [EW-1:0]   g_q, l_q;
  logic            rdy_q;

  logic signed [DIFF_W-1:0] trend_ext, thr_ext;
  dir_e            dir;
  logic            load_out;
  logic            out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  assign len       = clamp_len(cfg_i.window_length);
  assign old_sum   = OW'(ptr_q) + OW'(MAX_WINDOW) - OW'(len);
  assign old_idx   = (old_sum >= OW'(MAX_WINDOW)) ? IW'(old_sum - OW'(MAX_WINDOW))
                                                  : IW'(old_sum);
  assign evict     = fill_q >= len;
  assign fill_next = evict ? len : fill_q + 1'b1;
  assign full_next = fill_next == len;
  assign ptr_next  = (ptr_q == IW'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;

  assign num      = prod_q + NW'(dsum_q >> 1);
  assign trial    = {rem_q, low_q[QUOT_W-1]};
  assign ge       = trial >= {1'b0, dsum_q};
  assign rem_next = ge ? SW'(trial - {1'b0, dsum_q}) : SW'(trial);

  assign rsi_diff  = $signed({1'b0, quot_q}) - $signed({1'b0, rsi_q});
  assign slope     = {rsi_diff[RSI_W:0], 8'b0};
  assign ema_diff  = {slope[TREND_W-1], slope} - {trend_q[TREND_W-1], trend_q};
  assign alpha_s   = $signed({1'b0, cfg_i.alpha});
  assign ema_round = ema_q + PROD_W'(ROUND_HALF);

  assign trend_ext = {trend_q[TREND_W-1], trend_q};
  assign thr_ext   = $signed({2'b00, cfg_i.threshold});

  always_comb begin
    dir = DIR_NONE;
    if (seeded_q && (trend_ext > thr_ext)) begin
      dir = DIR_LONG;
    end else if (seeded_q && (trend_ext < -thr_ext)) begin
      dir = DIR_SHORT;
    end
  end

  always_comb begin
    state_d      = state_q;
    item_ready_o = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          state_d = (item_ctl_i.kind == TICK_CHANGE) ? ST_UPDATE : ST_DONE;
        end
      end
      ST_UPDATE: state_d = full_next ? ST_MUL : ST_DONE;
      ST_MUL:    state_d = (loss_q == '0) ? ST_EMA1 : ST_LOAD;
      ST_LOAD:   state_d = ST_DIV;
      ST_DIV:    state_d = (cnt_q == '0) ? ST_EMA1 : ST_DIV;
      ST_EMA1:   state_d = seeded_q ? ST_EMA2 : ST_DONE;
      ST_EMA2:   state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      gain_q      <= '0;
      loss_q      <= '0;
      rsi_q       <= RSI_MID;
      trend_q     <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (restart_i) begin
        fill_q <= '0;
        ptr_q  <= '0;
        gain_q <= '0;
        loss_q <= '0;
      end else if (state_q == ST_UPDATE) begin
        fill_q <= fill_next;
        ptr_q  <= ptr_next;
        gain_q <= gain_q - (evict ? SW'(rd_q[EW-1:0]) : '0) + SW'(g_q);
        loss_q <= loss_q - (evict ? SW'(rd_q[2*EW-1:EW]) : '0) + SW'(l_q);
      end
      if (state_q == ST_EMA1) begin
        rsi_q <= quot_q;
        if (!seeded_q) begin
          trend_q  <= slope;
          seeded_q <= 1'b1;
        end
      end else if (state_q == ST_EMA2) begin
        trend_q <= trend_q + ema_round[TREND_W+15:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        kind_q <= item_ctl_i.kind;
        g_q    <= item_ctl_i.up ? item_mag_i : '0;
        l_q    <= item_ctl_i.up ? '0 : item_mag_i;
        rdy_q  <= 1'b0;
      end
      ST_MUL: begin
        rdy_q  <= 1'b1;
        prod_q <= NW'(gain_q * RSI_FULL);
        dsum_q <= gain_q + loss_q;
        quot_q <= RSI_FULL;
      end
      ST_LOAD: begin
        rem_q <= num[NW-1:QUOT_W];
        low_q <= num[QUOT_W-1:0];
        cnt_q <= CNT_W'(QUOT_W - 1);
      end
      ST_DIV: begin
        rem_q  <= rem_next;
        low_q  <= {low_q[QUOT_W-2:0], 1'b0};
        quot_q <= {quot_q[QUOT_W-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
      end
      ST_EMA1: begin
        ema_q <= PROD_W'(ema_diff * alpha_s);
      end
      ST_DONE: begin
        if (load_out) begin
          out_data_q <= OUT_DATA_W'({dir, trend_q, rsi_q});
          out_user_q <= {seeded_q, rdy_q, kind_q != TICK_DROP};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      ring_mem[ptr_q] <= {l_q, g_q};
    end
    rd_q <= ring_mem[old_idx];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

`default_nettype wire

// ===== hdl/tick_rsi_trend_engine.sv =====
// ----------------------------------------------------------------------------
// tick_rsi_trend_engine
// Tick-driven simple-moving-average RSI with a smoothed slope and direction.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/tready        tdata: ask, bid
//   m_axis    out        m_axis_tvalid/tready        tdata: rsi, trend, dir
//   cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// A dropped or first tick goes from idle to done; an unfilled-window change
// passes through update first. An RSI tick runs update, multiply, load, the
// 15-step restoring divider and EMA; with no losses it skips load and divide.
// The front and a two-entry queue keep taking ticks while the back end works.
// Reset needs no clearing pass: ring entries past the fill count are not read.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_rsi_trend_engine #(
  parameter int MAX_WINDOW = trte_pkg::DEF_MAX_WINDOW,
  parameter int PRICE_BITS = trte_pkg::DEF_PRICE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // ask, bid
  input  logic [((2*PRICE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // rsi_value, trend_value, direction
  output logic [trte_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // accepted, rsi_ready, trend_valid
  output logic [trte_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [trte_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [trte_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import trte_pkg::*;

  localparam int MAG_W = PRICE_BITS + 1;
  localparam int Q_W   = $bits(tick_ctl_t) + MAG_W;

  cfg_t             cfg_q;
  logic             cfg_write;
  logic             restart;

  logic             f_valid, f_ready;
  tick_ctl_t        f_ctl, b_ctl;
  logic [MAG_W-1:0] f_mag, b_mag;
  logic             b_valid, b_ready;
  logic [Q_W-1:0]   b_data;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_write && (cfg_index_i == CFG_WINDOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length <= WLEN_RESET;
      cfg_q.alpha         <= ALPHA_RESET;
      cfg_q.spread_limit  <= SPREAD_RESET;
      cfg_q.threshold     <= THR_RESET;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_WINDOW: cfg_q.window_length <= cfg_data_i[WLEN_W-1:0];
        CFG_ALPHA:  cfg_q.alpha         <= cfg_data_i[ALPHA_W-1:0];
        CFG_SPREAD: cfg_q.spread_limit  <= cfg_data_i[SPREAD_W-1:0];
        CFG_THRESH: cfg_q.threshold     <= cfg_data_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  trte_front #(
    .PRICE_BITS(PRICE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .ask_i         (s_axis_tdata[PRICE_BITS-1:0]),
    .bid_i         (s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS]),
    .spread_limit_i(cfg_q.spread_limit),
    .q_valid_o     (f_valid),
    .q_ready_i     (f_ready),
    .q_ctl_o       (f_ctl),
    .q_mag_o       (f_mag)
  );

  trte_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i ({f_ctl, f_mag}),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready),
    .pop_data_o  (b_data)
  );

  assign b_ctl = b_data[Q_W-1:MAG_W];
  assign b_mag = b_data[MAG_W-1:0];

  trte_back #(
    .MAX_WINDOW(MAX_WINDOW),
    .PRICE_BITS(PRICE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .item_valid_i(b_valid),
    .item_ready_o(b_ready),
    .item_ctl_i  (b_ctl),
    .item_mag_i  (b_mag),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== hdl/trte_checker.sv =====
// ----------------------------------------------------------------------------
// trte_checker
// Port-level checks on the result stream of the tick RSI trend engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module trte_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [trte_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [trte_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import trte_pkg::*;

  logic [RSI_W-1:0] rsi;
  logic [DIR_W-1:0] dir;

  assign rsi = m_axis_tdata[OUT_RSI_LSB +: RSI_W];
  assign dir = m_axis_tdata[OUT_DIR_LSB +: DIR_W];

  `TRTE_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "result during reset")
  `TRTE_ASSERT(a_result_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `TRTE_ASSERT(a_ready_implies_seeded, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[USR_RSI_READY] |-> m_axis_tuser[USR_ACCEPTED] && m_axis_tuser[USR_TREND_VALID], "RSI without accepted tick or seeded trend")
  `TRTE_ASSERT(a_dir_needs_trend, clk_i, rst_ni, m_axis_tvalid && (dir != DIR_NONE) |-> m_axis_tuser[USR_TREND_VALID], "direction before trend seeded")
  `TRTE_ASSERT(a_rsi_range, clk_i, rst_ni, m_axis_tvalid |-> rsi <= RSI_FULL, "RSI above 100 points")

endmodule

bind tick_rsi_trend_engine trte_checker u_checker (.*);

`default_nettype wire
